@@ design/rrsp_pkg.sv @@
package rrsp_pkg;

  localparam int unsigned DIGEST_MAX_BYTES = 20;
  localparam logic [31:0] MAGIC_RESET = 32'h178e553c;

  localparam int unsigned LEN_W = 5;
  localparam int unsigned OUT_DATA_W = 80;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] KIND_COUNT  = 2'd0;
  localparam logic [1:0] KIND_DIGEST = 2'd1;
  localparam logic [1:0] KIND_REFCNT = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  typedef enum logic [6:0] {
    PH_MAGIC  = 7'b0000001,
    PH_COUNT  = 7'b0000010,
    PH_LEN    = 7'b0000100,
    PH_DIGEST = 7'b0001000,
    PH_REFCNT = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_ERROR  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [32:0]      value;
    logic [LEN_W-1:0] dlen;
    logic [LEN_W-1:0] pos;
    logic [31:0]      entry;
    logic             last;
  } result_t;

endpackage

@@ design/refcount_record_stream_parser.sv @@
// Channel  Dir  tdata (low bit up)                               tuser          tlast
// in_      in   data_byte[7:0]                                   start_of_file  -
// out_     out  value[32:0] digest_length[37:33] byte_position   kind[1:0]      last_entry
//               [42:38] entry_number[74:43], zero pad [79:75]
// cfg_     in   cfg_wr_data = expected_magic, written when cfg_wr_en is high
//
// The parser takes one byte per cycle while in_tready is high and decides its result in that same cycle.
// A result is pushed into the result queue when its byte is accepted; out_tvalid comes from the queue's registers.
// The two-entry result queue sets the stall point: in_tready drops only while it is full.
// Reset is synchronous on rst_n low and restores the magic register to its default.
module refcount_record_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // start_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [rrsp_pkg::OUT_DATA_W-1:0] out_tdata, // value, digest_length,
                                                      // byte_position, entry_number
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast   // last_entry
);

  logic              q_full;
  logic              push;
  logic              in_acc;
  rrsp_pkg::result_t res;
  rrsp_pkg::result_t head;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  rrsp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_acc      (in_acc),
    .in_byte     (in_tdata),
    .in_sof      (in_tuser),
    .push        (push),
    .res         (res)
  );

  rrsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (q_full),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  assign out_tdata = {5'b0, head.entry, head.pos, head.dlen, head.value};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

@@ design/rrsp_front.sv @@
module rrsp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  input  logic             in_acc,
  input  logic [7:0]       in_byte,
  input  logic             in_sof,
  output logic             push,
  output rrsp_pkg::result_t res
);

  localparam logic [2:0] VIDX_SAT = 3'd5;

  logic [31:0]               magic_exp_r;
  rrsp_pkg::phase_t          phase_r, phase_nxt, phase_e;
  logic [31:0]               magic_r, magic_nxt, magic_e;
  logic [1:0]                hdr_r, hdr_nxt, hdr_e;
  logic [31:0]               acc_r, acc_nxt;
  logic [2:0]                vidx_r, vidx_nxt;
  logic                      neg_r, neg_nxt;
  logic [31:0]               remain_r, remain_nxt;
  logic [31:0]               entry_r, entry_nxt;
  logic [rrsp_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [rrsp_pkg::LEN_W-1:0] seen_r, seen_nxt;

  logic [31:0] v_contrib, v_acc, v_res;
  logic [2:0]  v_idx;
  logic        v_neg, v_done;
  logic [rrsp_pkg::LEN_W-1:0] len_clamp;
  logic [rrsp_pkg::LEN_W:0]   seen_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_exp_r <= rrsp_pkg::MAGIC_RESET;
    end else if (cfg_wr_en) begin
      magic_exp_r <= cfg_wr_data;
    end
  end

  always_comb begin
    case (vidx_r)
      3'd1:    v_contrib = {19'b0, in_byte[6:0], 6'b0};
      3'd2:    v_contrib = {12'b0, in_byte[6:0], 13'b0};
      3'd3:    v_contrib = {5'b0, in_byte[6:0], 20'b0};
      3'd4:    v_contrib = {in_byte[4:0], 27'b0};
      default: v_contrib = '0;
    endcase
    if (vidx_r == 3'd0) begin
      v_neg = in_byte[0];
      v_acc = {26'b0, in_byte[6:1]};
      v_idx = 3'd1;
    end else begin
      v_neg = neg_r;
      v_acc = acc_r | v_contrib;
      v_idx = (vidx_r >= VIDX_SAT) ? VIDX_SAT : vidx_r + 3'd1;
    end
    v_done = !in_byte[7];
    v_res  = v_neg ? (32'd0 - v_acc) : v_acc;
  end

  assign len_clamp = (in_byte > 8'(rrsp_pkg::DIGEST_MAX_BYTES)) ?
                     rrsp_pkg::LEN_W'(rrsp_pkg::DIGEST_MAX_BYTES) :
                     in_byte[rrsp_pkg::LEN_W-1:0];
  assign seen_inc  = {1'b0, seen_r} + {{rrsp_pkg::LEN_W{1'b0}}, 1'b1};

  assign phase_e = in_sof ? rrsp_pkg::PH_MAGIC : phase_r;
  assign magic_e = in_sof ? 32'd0 : magic_r;
  assign hdr_e   = in_sof ? 2'd0 : hdr_r;

  always_comb begin
    phase_nxt  = phase_r;
    magic_nxt  = magic_r;
    hdr_nxt    = hdr_r;
    acc_nxt    = acc_r;
    vidx_nxt   = vidx_r;
    neg_nxt    = neg_r;
    remain_nxt = remain_r;
    entry_nxt  = entry_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    push       = 1'b0;
    res        = '0;
    if (in_acc) begin
      if (in_sof) begin
        phase_nxt  = rrsp_pkg::PH_MAGIC;
        magic_nxt  = '0;
        hdr_nxt    = '0;
        acc_nxt    = '0;
        vidx_nxt   = '0;
        neg_nxt    = 1'b0;
        remain_nxt = '0;
        entry_nxt  = '0;
        len_nxt    = '0;
        seen_nxt   = '0;
      end
      case (phase_e)
        rrsp_pkg::PH_MAGIC: begin
          magic_nxt = {magic_e[23:0], in_byte};
          hdr_nxt   = hdr_e + 2'd1;
          if (hdr_nxt == 2'd0) begin
            if (magic_nxt != magic_exp_r) begin
              phase_nxt = rrsp_pkg::PH_ERROR;
              push      = 1'b1;
              res.kind  = rrsp_pkg::KIND_ERROR;
              res.value = {1'b0, magic_nxt};
            end else begin
              phase_nxt = rrsp_pkg::PH_COUNT;
            end
          end
        end
        rrsp_pkg::PH_COUNT, rrsp_pkg::PH_REFCNT: begin
          if (v_done) begin
            acc_nxt  = '0;
            vidx_nxt = '0;
            neg_nxt  = 1'b0;
            push     = 1'b1;
            if (phase_e == rrsp_pkg::PH_COUNT) begin
              remain_nxt = v_res;
              entry_nxt  = '0;
              phase_nxt  = (v_res != 32'd0) ? rrsp_pkg::PH_LEN : rrsp_pkg::PH_DONE;
              res.kind   = rrsp_pkg::KIND_COUNT;
              res.value  = {1'b0, v_res};
            end else begin
              remain_nxt = remain_r - 32'd1;
              entry_nxt  = entry_r + 32'd1;
              phase_nxt  = (remain_nxt != 32'd0) ? rrsp_pkg::PH_LEN : rrsp_pkg::PH_DONE;
              res.kind   = rrsp_pkg::KIND_REFCNT;
              res.value  = {v_res[31], v_res};
              res.dlen   = len_r;
              res.entry  = entry_r;
              res.last   = (remain_r == 32'd1);
            end
          end else begin
            acc_nxt  = v_acc;
            vidx_nxt = v_idx;
            neg_nxt  = v_neg;
          end
        end
        rrsp_pkg::PH_LEN: begin
          len_nxt   = len_clamp;
          seen_nxt  = '0;
          phase_nxt = (len_clamp != '0) ? rrsp_pkg::PH_DIGEST : rrsp_pkg::PH_REFCNT;
        end
        rrsp_pkg::PH_DIGEST: begin
          push      = 1'b1;
          res.kind  = rrsp_pkg::KIND_DIGEST;
          res.value = {25'b0, in_byte};
          res.dlen  = len_r;
          res.pos   = seen_r;
          res.entry = entry_r;
          seen_nxt  = seen_inc[rrsp_pkg::LEN_W-1:0];
          if (seen_inc >= {1'b0, len_r}) begin
            phase_nxt = rrsp_pkg::PH_REFCNT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rrsp_pkg::PH_MAGIC;
      magic_r  <= '0;
      hdr_r    <= '0;
      acc_r    <= '0;
      vidx_r   <= '0;
      neg_r    <= 1'b0;
      remain_r <= '0;
      entry_r  <= '0;
      len_r    <= '0;
      seen_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      magic_r  <= magic_nxt;
      hdr_r    <= hdr_nxt;
      acc_r    <= acc_nxt;
      vidx_r   <= vidx_nxt;
      neg_r    <= neg_nxt;
      remain_r <= remain_nxt;
      entry_r  <= entry_nxt;
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

@@ design/rrsp_queue.sv @@
module rrsp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rrsp_pkg::result_t push_data,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop_ready,
  output rrsp_pkg::result_t pop_data
);

  localparam logic [rrsp_pkg::Q_PTR_W-1:0] PTR_LAST =
    rrsp_pkg::Q_PTR_W'(rrsp_pkg::Q_DEPTH - 1);
  localparam logic [rrsp_pkg::Q_PTR_W-1:0] PTR_ONE =
    rrsp_pkg::Q_PTR_W'(1);
  localparam logic [rrsp_pkg::Q_CNT_W-1:0] CNT_FULL =
    rrsp_pkg::Q_CNT_W'(rrsp_pkg::Q_DEPTH);
  localparam logic [rrsp_pkg::Q_CNT_W-1:0] CNT_ONE =
    rrsp_pkg::Q_CNT_W'(1);

  rrsp_pkg::result_t             slot_r [rrsp_pkg::Q_DEPTH];
  logic [rrsp_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rrsp_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rrsp_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_ONE;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_ONE;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_ONE;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ design/rrsp_checker.sv @@
module rrsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [rrsp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled output word changed.");

  a_last_only_refcnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == rrsp_pkg::KIND_REFCNT)
    else $error("Last entry flag on a word that is not a reference count.");

  a_header_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == rrsp_pkg::KIND_COUNT || out_tuser == rrsp_pkg::KIND_ERROR)
    |-> out_tdata[74:33] == '0 && out_tdata[32] == 1'b0)
    else $error("Header word carries entry fields.");

  a_digest_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rrsp_pkg::KIND_DIGEST
    |-> out_tdata[42:38] < out_tdata[37:33] && out_tdata[32:8] == '0)
    else $error("Digest byte position out of range.");

endmodule

bind refcount_record_stream_parser rrsp_checker u_rrsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
